// File: rtl/swmf_pkg.sv
// Shared types and constants for the sliding window median filter.
// Depends on nothing; every other file in rtl/ imports it.
package swmf_pkg;

   // Width of one sample and of one median transaction.
   localparam int SAMPLE_W = 16;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Control handed from one rank cell to the next one up the chain.
   typedef struct packed {
      logic gt;        // cell holds no sample or a sample above the incoming one
      logic del_seen;  // the evicted sample sits in this cell or one below it
   } cell_ctl_type;

endpackage

// File: rtl/swmf_stream_if.sv
// Valid/ready channels for the sliding window median filter.
// Depends on swmf_pkg for the sample type.
interface swmf_req_if;
   import swmf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface swmf_rsp_if;
   import swmf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type median;

   modport source (output valid, output median, input ready);
   modport sink (input valid, input median, output ready);
endinterface

// File: rtl/swmf_cell.sv
// One rank cell of the sorted window: holds a sample and its store slot.
// Depends on swmf_pkg; instantiated as a chain by the top level.
module swmf_cell #(
   parameter int SLOT_W = 3
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic                   cell_valid,
   input  logic                   evict_slot_en,
   input  logic [SLOT_W-1:0]      evict_slot,
   input  swmf_pkg::sample_type   new_sample,
   input  swmf_pkg::cell_ctl_type left_ctl,
   input  swmf_pkg::sample_type   left_value,
   input  logic [SLOT_W-1:0]      left_slot,
   input  logic                   right_gt,
   input  swmf_pkg::sample_type   right_value,
   input  logic [SLOT_W-1:0]      right_slot,
   output swmf_pkg::cell_ctl_type ctl_out,
   output swmf_pkg::sample_type   value_out,
   output logic [SLOT_W-1:0]      slot_out,
   output swmf_pkg::sample_type   value_next
);
   import swmf_pkg::*;

   sample_type        value_ff;
   sample_type        value_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic              own_gt;
   logic              del_here;
   logic              at_or_after;

   // Compare against the incoming sample and spot the evicted entry
   assign own_gt      = !cell_valid || (value_ff > new_sample);
   assign del_here    = evict_slot_en && (slot_ff == evict_slot);
   assign at_or_after = left_ctl.del_seen || del_here;

   assign ctl_out.gt       = own_gt;
   assign ctl_out.del_seen = at_or_after;
   assign value_out        = value_ff;
   assign slot_out         = slot_ff;
   assign value_next       = value_in;

   // Pick the next content: own, a neighbour's, or the new sample
   always_comb begin
      value_in = value_ff;
      slot_in  = slot_ff;
      if (at_or_after) begin
         if (!right_gt) begin
            value_in = right_value;
            slot_in  = right_slot;
         end else if (del_here ? !left_ctl.gt : !own_gt) begin
            value_in = new_sample;
            slot_in  = evict_slot;
         end else if (del_here) begin
            value_in = left_value;
            slot_in  = left_slot;
         end
      end else if (own_gt) begin
         if (!left_ctl.gt) begin
            value_in = new_sample;
            slot_in  = evict_slot;
         end else begin
            value_in = left_value;
            slot_in  = left_slot;
         end
      end
   end

   // Load on every accepted transaction
   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

// File: rtl/sliding_window_median_filter_core.sv
// Top level of the sliding window median filter: rank cell chain and result register.
// Depends on swmf_pkg, swmf_stream_if and swmf_cell.
//
//   channel   dir   handshake          payload
//   req_if    in    valid / ready      sample [15:0]
//   rsp_if    out   valid / ready      median [15:0]
//
// One transaction per clock unless intake stalls; the median follows in the next cycle.
// The whole window reorders in the cell chain in the cycle of acceptance: each cell
// compares itself with the new sample and takes its own, a neighbour's or the new value.
// A held median stalls intake only while rsp_if.ready is low.
// Synchronous reset empties the window; no clearing pass is needed.
module sliding_window_median_filter_core #(
   parameter int WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   swmf_req_if.sink    req_if,
   swmf_rsp_if.source  rsp_if
);
   import swmf_pkg::*;

   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int COUNT_W = $clog2(WINDOW + 1);

   logic [SLOT_W-1:0]  write_slot_ff;
   logic [SLOT_W-1:0]  write_slot_in;
   logic [COUNT_W-1:0] fill_count_ff;
   logic [COUNT_W-1:0] fill_count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   sample_type         median_ff;
   sample_type         median_in;
   logic               advance;
   logic               full;
   logic [COUNT_W-1:0] mid_rank;

   cell_ctl_type       ctl     [WINDOW];
   sample_type         values  [WINDOW];
   logic [SLOT_W-1:0]  slots   [WINDOW];
   sample_type         nexts   [WINDOW];
   logic [WINDOW-1:0]  evicting;

   assign advance     = req_if.valid && req_if.ready;
   assign full        = (fill_count_ff == COUNT_W'(WINDOW));
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;

   // Build the chain of rank cells, lowest rank first
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      cell_ctl_type      left_ctl;
      sample_type        left_value;
      logic [SLOT_W-1:0] left_slot;
      logic              right_gt;
      sample_type        right_value;
      logic [SLOT_W-1:0] right_slot;

      if (i == 0) begin : g_bottom
         assign left_ctl   = '{gt: 1'b0, del_seen: 1'b0};
         assign left_value = '0;
         assign left_slot  = '0;
      end else begin : g_link_left
         assign left_ctl   = ctl[i-1];
         assign left_value = values[i-1];
         assign left_slot  = slots[i-1];
      end

      if (i == WINDOW - 1) begin : g_top
         assign right_gt    = 1'b1;
         assign right_value = '0;
         assign right_slot  = '0;
      end else begin : g_link_right
         assign right_gt    = ctl[i+1].gt;
         assign right_value = values[i+1];
         assign right_slot  = slots[i+1];
      end

      swmf_cell #(
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock         (clock),
         .advance       (advance),
         .cell_valid    (COUNT_W'(i) < fill_count_ff),
         .evict_slot_en (full),
         .evict_slot    (write_slot_ff),
         .new_sample    (req_if.sample),
         .left_ctl      (left_ctl),
         .left_value    (left_value),
         .left_slot     (left_slot),
         .right_gt      (right_gt),
         .right_value   (right_value),
         .right_slot    (right_slot),
         .ctl_out       (ctl[i]),
         .value_out     (values[i]),
         .slot_out      (slots[i]),
         .value_next    (nexts[i])
      );

      assign evicting[i] = full && (slots[i] == write_slot_ff);
   end

   // Select the middle rank of the reordered window
   assign mid_rank  = fill_count_ff >> 1;
   assign median_in = nexts[mid_rank[SLOT_W-1:0]];

   // Advance the write slot and the fill count
   always_comb begin
      write_slot_in = write_slot_ff;
      fill_count_in = fill_count_ff;
      if (advance) begin
         if (write_slot_ff == SLOT_W'(WINDOW - 1)) begin
            write_slot_in = '0;
         end else begin
            write_slot_in = write_slot_ff + 1'b1;
         end
         if (!full) begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         median_ff <= median_in;
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.median = median_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= COUNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_slot_bounded: assert property (@(posedge clock) disable iff (reset)
      write_slot_ff <= SLOT_W'(WINDOW - 1))
      else $error("write slot beyond window");

   a_one_eviction: assert property (@(posedge clock) disable iff (reset)
      (advance && full) |-> $onehot(evicting))
      else $error("evicted slot not held by exactly one cell");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");
`endif

endmodule
